// ===== hdl/gvdd_pkg.sv =====
package gvdd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned POS_W   = 4;
    localparam int unsigned CTRL_N  = 4;

    localparam logic [POS_W-1:0] LAST_POS = 4'hf;

    // index of the last control byte per mode
    localparam logic [1:0] CTRL_LAST_SHORT = 2'd1;
    localparam logic [1:0] CTRL_LAST_WIDE  = 2'd3;

    localparam logic [BYTE_W-1:0] MODE_BYTE_PREFIX = 8'h00;
    localparam logic [BYTE_W-1:0] MODE_BYTE_SHORT  = 8'h01;

    typedef enum logic [1:0] {
        PH_MODE = 2'd0,
        PH_CTRL = 2'd1,
        PH_DATA = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        MODE_PREFIX = 2'd0,
        MODE_SHORT  = 2'd1,
        MODE_WIDE   = 2'd2
    } t_mode;

    // item between the parse stage and the base-add stage
    typedef struct packed {
        logic               clr;
        logic               last;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] sum;
    } t_mid_item;

endpackage

// ===== hdl/group_varint_delta_decoder.sv =====
// Channel | Direction | Handshake           | Payload
// input   | in        | i_valid / o_ready   | i_in_byte, i_stream_start
// result  | out       | o_valid / i_ready   | o_value, o_position_in_block, o_block_end
//
// One compressed byte accepted per cycle, with no bubbles, while o_ready is high.
// A byte that completes a delta is registered in the parse/sum (middle) stage,
// then passes the base add into the output register that drives o_valid.
// Reset (i_rst_n low, synchronous) returns to waiting for a mode byte, base zero.
// o_ready drops only while both the middle stage and the output register are
// full and i_ready is low.
module group_varint_delta_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [gvdd_pkg::BYTE_W-1:0]   i_in_byte,
    input  logic                          i_stream_start,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [gvdd_pkg::VALUE_W-1:0]  o_value,
    output logic [gvdd_pkg::POS_W-1:0]    o_position_in_block,
    output logic                          o_block_end
);
    import gvdd_pkg::*;

    // parse state
    t_phase             r_phase, n_phase;
    t_mode              r_mode, n_mode;
    logic [1:0]         r_ctrl_cnt, n_ctrl_cnt;
    logic [POS_W-1:0]   r_vidx, n_vidx;
    logic [1:0]         r_bidx, n_bidx;
    logic [VALUE_W-1:0] r_acc, n_acc;
    logic [VALUE_W-1:0] r_sum, n_sum;
    logic [BYTE_W-1:0]  r_ctrl [CTRL_N];

    // middle and output stages
    logic               r_mid_valid;
    t_mid_item          r_mid, n_mid;
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;
    logic [POS_W-1:0]   r_out_pos;
    logic               r_out_last;
    logic [VALUE_W-1:0] r_base;

    logic               w_accept;
    logic               w_mid_load;
    logic               w_mid_move;
    logic               w_out_free;
    logic               w_ctrl_we;
    logic               w_start;
    t_mode              w_new_mode;
    logic [1:0]         w_ctrl_sel;
    logic [BYTE_W-1:0]  w_ctrl_byte;
    logic [1:0]         w_field;
    logic [VALUE_W-1:0] w_acc_new;
    logic [VALUE_W-1:0] w_sum_new;
    logic               w_emit;
    logic [VALUE_W-1:0] w_result;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_mid_move = r_mid_valid && (r_mid.clr || w_out_free);
    assign o_ready    = !r_mid_valid || w_mid_move;
    assign w_accept   = i_valid && o_ready;

    always_comb begin
        if (i_in_byte == MODE_BYTE_PREFIX) begin
            w_new_mode = MODE_PREFIX;
        end else if (i_in_byte == MODE_BYTE_SHORT) begin
            w_new_mode = MODE_SHORT;
        end else begin
            w_new_mode = MODE_WIDE;
        end
    end

    // delta length field for the current value
    assign w_ctrl_sel  = (r_mode == MODE_SHORT) ? {1'b0, r_vidx[3]} : r_vidx[3:2];
    assign w_ctrl_byte = r_ctrl[w_ctrl_sel];
    always_comb begin
        if (r_mode == MODE_SHORT) begin
            w_field = {1'b0, w_ctrl_byte[r_vidx[2:0]]};
        end else begin
            w_field = w_ctrl_byte[{r_vidx[1:0], 1'b0} +: 2];
        end
    end

    assign w_acc_new = r_acc | (VALUE_W'(i_in_byte) << {r_bidx, 3'b000});

    always_comb begin
        w_sum_new = r_sum + w_acc_new;
        if (r_mode == MODE_SHORT) begin
            w_sum_new[VALUE_W-1:16] = '0;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_mode     = r_mode;
        n_ctrl_cnt = r_ctrl_cnt;
        n_vidx     = r_vidx;
        n_bidx     = r_bidx;
        n_acc      = r_acc;
        n_sum      = r_sum;
        w_ctrl_we  = 1'b0;
        w_start    = 1'b0;
        w_emit     = 1'b0;
        w_mid_load = 1'b0;
        n_mid.clr  = 1'b0;
        n_mid.last = (r_vidx == LAST_POS);
        n_mid.pos  = r_vidx;
        n_mid.sum  = w_sum_new;
        if (w_accept) begin
            if (i_stream_start) begin
                w_start    = 1'b1;
                w_mid_load = 1'b1;
                n_mid.clr  = 1'b1;
            end else begin
                case (r_phase)
                    PH_CTRL: begin
                        w_ctrl_we = 1'b1;
                        if ((r_mode == MODE_SHORT && r_ctrl_cnt == CTRL_LAST_SHORT) ||
                            (r_mode != MODE_SHORT && r_ctrl_cnt == CTRL_LAST_WIDE)) begin
                            n_phase    = PH_DATA;
                            n_ctrl_cnt = '0;
                        end else begin
                            n_ctrl_cnt = r_ctrl_cnt + 2'd1;
                        end
                    end
                    PH_DATA: begin
                        if (r_mode == MODE_PREFIX) begin
                            n_mid.sum = VALUE_W'(i_in_byte);
                            w_emit    = 1'b1;
                        end else if (r_bidx < w_field) begin
                            n_acc  = w_acc_new;
                            n_bidx = r_bidx + 2'd1;
                        end else begin
                            n_sum  = w_sum_new;
                            n_acc  = '0;
                            n_bidx = '0;
                            w_emit = 1'b1;
                        end
                    end
                    default: begin
                        w_start = 1'b1;
                    end
                endcase
            end
        end
        if (w_emit) begin
            w_mid_load = 1'b1;
            if (r_vidx == LAST_POS) begin
                n_phase = PH_MODE;
                n_vidx  = '0;
                n_sum   = '0;
            end else begin
                n_vidx = r_vidx + 4'd1;
            end
        end
        if (w_start) begin
            n_mode     = w_new_mode;
            n_phase    = (w_new_mode == MODE_PREFIX) ? PH_DATA : PH_CTRL;
            n_ctrl_cnt = '0;
            n_vidx     = '0;
            n_bidx     = '0;
            n_acc      = '0;
            n_sum      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_MODE;
            r_mode     <= MODE_PREFIX;
            r_ctrl_cnt <= '0;
            r_vidx     <= '0;
            r_bidx     <= '0;
            r_acc      <= '0;
            r_sum      <= '0;
        end else begin
            r_phase    <= n_phase;
            r_mode     <= n_mode;
            r_ctrl_cnt <= n_ctrl_cnt;
            r_vidx     <= n_vidx;
            r_bidx     <= n_bidx;
            r_acc      <= n_acc;
            r_sum      <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl_we) begin
            r_ctrl[r_ctrl_cnt] <= i_in_byte;
        end
    end

    // middle stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
        end else if (w_mid_load) begin
            r_mid_valid <= 1'b1;
        end else if (w_mid_move) begin
            r_mid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mid_load) begin
            r_mid <= n_mid;
        end
    end

    assign w_result = r_base + r_mid.sum;

    // base add and output register; stream start clears base in order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_base      <= '0;
        end else begin
            if (w_mid_move && !r_mid.clr) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_mid_move && r_mid.clr) begin
                r_base <= '0;
            end else if (w_mid_move && r_mid.last) begin
                r_base <= w_result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mid_move && !r_mid.clr) begin
            r_out_value <= w_result;
            r_out_pos   <= r_mid.pos;
            r_out_last  <= r_mid.last;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_value             = r_out_value;
    assign o_position_in_block = r_out_pos;
    assign o_block_end         = r_out_last;

endmodule

// ===== hdl/gvdd_checker.sv =====
module gvdd_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          o_ready,
    input  logic [gvdd_pkg::BYTE_W-1:0]   i_in_byte,
    input  logic                          i_stream_start,
    input  logic                          o_valid,
    input  logic                          i_ready,
    input  logic [gvdd_pkg::VALUE_W-1:0]  o_value,
    input  logic [gvdd_pkg::POS_W-1:0]    o_position_in_block,
    input  logic                          o_block_end
);
    import gvdd_pkg::*;

    logic [POS_W-1:0] r_prev_pos;
    logic             w_out_xfer;

    assign w_out_xfer = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pos <= LAST_POS;
        end else if (w_out_xfer) begin
            r_prev_pos <= o_position_in_block;
        end
    end

    // a value inside a block follows its predecessor
    a_pos_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_xfer && o_position_in_block != '0) |->
            o_position_in_block == POS_W'(r_prev_pos + 4'd1))
        else $error("position skipped or repeated");

    a_end_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_block_end == (o_position_in_block == LAST_POS)))
        else $error("block end flag does not match position");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_value) &&
            $stable(o_position_in_block)))
        else $error("stalled result changed");

endmodule

bind group_varint_delta_decoder gvdd_checker u_gvdd_checker (.*);
